[design/top_five_wealth_board_top_assert.svh]
// Assertion macros used by the wealth board controller.
// Each macro expects signals named clock and reset in the using module.
`ifndef TOP_FIVE_WEALTH_BOARD_TOP_ASSERT_SVH
`define TOP_FIVE_WEALTH_BOARD_TOP_ASSERT_SVH

// Same-cycle implication.
`define TFWB_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wealth board assertion failed");

// Next-cycle implication.
`define TFWB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wealth board assertion failed");

`endif

[design/tfwb_pkg.sv]
`default_nettype none
package tfwb_pkg;

   localparam int unsigned WEALTH_W = 32;
   localparam int unsigned IDENT_W = 16;
   localparam int unsigned CLASS_W = 8;
   localparam int unsigned RANK_W = 3;

   localparam logic [CLASS_W-1:0] CLASS_LIMIT_RESET = 8'd10;
   localparam logic [IDENT_W-1:0] EMPTY_IDENT = 16'hFFFF;
   localparam logic signed [WEALTH_W-1:0] EMPTY_WEALTH = 32'sd0;

   localparam logic KIND_OFFER = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } tfwb_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic offer;      // an offer item is transferred this cycle
      logic shift;      // a board entry is transferred on the result channel
      logic csr_write;  // the class limit register is written
   } tfwb_cmd_type;

endpackage
`default_nettype wire

[design/top_five_wealth_board_top.sv]
// Top-five wealth board.
// Request channel (req_valid/req_stall): each transfer is either an offer
// (req_kind low) or a finish (req_kind high). An offer that is active, whose
// class is below the class limit and whose wealth beats the bottom entry is
// inserted; the board is updated at the transfer edge. Offers can be taken
// every cycle while no finish is in progress and produce no result.
// A finish makes the block stall the request channel and send BOARD_SIZE
// results on the response channel (rsp_valid/rsp_stall), richest first, with
// rsp_last_entry on the final one. The first result appears the cycle after
// the finish transfer, and the board shifts up one entry per result transfer.
// While the receiver stalls, the current entry holds and nothing else moves.
// After the last entry the board is empty (wealth 0, identifier 65535).
// The class limit is written over csr_valid/csr_ready while no finish is in
// progress. Reset empties the board and sets the class limit to 10.
`default_nettype none
module top_five_wealth_board_top
   import tfwb_pkg::*;
#(
   parameter int unsigned BOARD_SIZE = 5
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_kind,
   input  wire logic                       req_slot_active,
   input  wire logic [CLASS_W-1:0]         req_slot_class,
   input  wire logic signed [WEALTH_W-1:0] req_slot_wealth,
   input  wire logic [IDENT_W-1:0]         req_slot_ident,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [RANK_W-1:0]               rsp_rank,
   output logic [IDENT_W-1:0]              rsp_entry_ident,
   output logic signed [WEALTH_W-1:0]      rsp_entry_wealth,
   output logic                            rsp_last_entry,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CLASS_W-1:0]         csr_class_limit
);

   tfwb_cmd_type cmd;

   tfwb_ctrl #(
      .BOARD_SIZE(BOARD_SIZE)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_kind       (req_kind),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rank       (rsp_rank),
      .rsp_last_entry (rsp_last_entry),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .cmd            (cmd)
   );

   tfwb_datapath #(
      .BOARD_SIZE(BOARD_SIZE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_class_limit  (csr_class_limit),
      .req_slot_active  (req_slot_active),
      .req_slot_class   (req_slot_class),
      .req_slot_wealth  (req_slot_wealth),
      .req_slot_ident   (req_slot_ident),
      .rsp_entry_ident  (rsp_entry_ident),
      .rsp_entry_wealth (rsp_entry_wealth)
   );

endmodule
`default_nettype wire

[design/tfwb_datapath.sv]
`default_nettype none
module tfwb_datapath
   import tfwb_pkg::*;
#(
   parameter int unsigned BOARD_SIZE = 5
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire tfwb_cmd_type               cmd,
   input  wire logic [CLASS_W-1:0]         csr_class_limit,
   input  wire logic                       req_slot_active,
   input  wire logic [CLASS_W-1:0]         req_slot_class,
   input  wire logic signed [WEALTH_W-1:0] req_slot_wealth,
   input  wire logic [IDENT_W-1:0]         req_slot_ident,
   output logic [IDENT_W-1:0]              rsp_entry_ident,
   output logic signed [WEALTH_W-1:0]      rsp_entry_wealth
);

   logic [CLASS_W-1:0]         class_limit_ff;
   logic signed [WEALTH_W-1:0] wealth_ff [BOARD_SIZE];
   logic signed [WEALTH_W-1:0] wealth_in [BOARD_SIZE];
   logic [IDENT_W-1:0]         ident_ff  [BOARD_SIZE];
   logic [IDENT_W-1:0]         ident_in  [BOARD_SIZE];
   logic [BOARD_SIZE-1:0]      gt;
   logic                       qualified;

   always_comb begin
      for (int i = 0; i < BOARD_SIZE; i++) begin
         gt[i] = req_slot_wealth > wealth_ff[i];
      end
   end

   assign qualified = req_slot_active && (req_slot_class < class_limit_ff);

   // The board is kept in descending order, so the compare results form a run of
   // ones from some position to the bottom. The newcomer lands at the top of that run.
   always_comb begin
      for (int i = 0; i < BOARD_SIZE; i++) begin
         wealth_in[i] = wealth_ff[i];
         ident_in[i] = ident_ff[i];
      end
      if (cmd.shift) begin
         // Shifting the board up on every transfer empties it by the last entry.
         for (int i = 0; i < BOARD_SIZE - 1; i++) begin
            wealth_in[i] = wealth_ff[i + 1];
            ident_in[i] = ident_ff[i + 1];
         end
         wealth_in[BOARD_SIZE-1] = EMPTY_WEALTH;
         ident_in[BOARD_SIZE-1] = EMPTY_IDENT;
      end else if (cmd.offer && qualified) begin
         if (gt[0]) begin
            wealth_in[0] = req_slot_wealth;
            ident_in[0] = req_slot_ident;
         end
         for (int i = 1; i < BOARD_SIZE; i++) begin
            if (gt[i]) begin
               if (gt[i-1]) begin
                  wealth_in[i] = wealth_ff[i-1];
                  ident_in[i] = ident_ff[i-1];
               end else begin
                  wealth_in[i] = req_slot_wealth;
                  ident_in[i] = req_slot_ident;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_limit_ff <= CLASS_LIMIT_RESET;
         for (int i = 0; i < BOARD_SIZE; i++) begin
            wealth_ff[i] <= EMPTY_WEALTH;
            ident_ff[i] <= EMPTY_IDENT;
         end
      end else begin
         if (cmd.csr_write) begin
            class_limit_ff <= csr_class_limit;
         end
         for (int i = 0; i < BOARD_SIZE; i++) begin
            wealth_ff[i] <= wealth_in[i];
            ident_ff[i] <= ident_in[i];
         end
      end
   end

   assign rsp_entry_wealth = wealth_ff[0];
   assign rsp_entry_ident = ident_ff[0];

endmodule
`default_nettype wire

[design/tfwb_ctrl.sv]
`default_nettype none
module tfwb_ctrl
   import tfwb_pkg::*;
#(
   parameter int unsigned BOARD_SIZE = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_kind,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [RANK_W-1:0]  rsp_rank,
   output logic               rsp_last_entry,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   output tfwb_cmd_type       cmd
);

`include "top_five_wealth_board_top_assert.svh"

   localparam int unsigned CNT_W = (BOARD_SIZE > 1) ? $clog2(BOARD_SIZE) : 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BOARD_SIZE - 1);

   tfwb_state_type   state_ff;
   tfwb_state_type   state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             req_xfer;
   logic             rsp_xfer;
   logic             finish_xfer;
   logic             last;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;
   assign finish_xfer = req_xfer && (req_kind == KIND_FINISH);
   assign last = (cnt_ff == LAST_CNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      req_stall = 1'b0;
      rsp_valid = 1'b0;
      csr_ready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            cmd.csr_write = csr_valid;
            cmd.offer = req_valid && (req_kind == KIND_OFFER);
            if (req_valid && (req_kind == KIND_FINISH)) begin
               state_in = ST_EMIT;
               cnt_in = '0;
            end
         end
         ST_EMIT: begin
            req_stall = 1'b1;
            rsp_valid = 1'b1;
            cmd.shift = !rsp_stall;
            if (!rsp_stall) begin
               if (last) begin
                  state_in = ST_IDLE;
                  cnt_in = '0;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_rank = RANK_W'(cnt_ff);
   assign rsp_last_entry = rsp_valid && last;

   `TFWB_ASSERT_NOW(a_no_overlap, !req_stall, !rsp_valid)
   `TFWB_ASSERT_NEXT(a_finish_starts, finish_xfer, rsp_valid && (cnt_ff == '0))
   `TFWB_ASSERT_NEXT(a_emit_continues, rsp_xfer && !last, rsp_valid)
   `TFWB_ASSERT_NEXT(a_emit_ends, rsp_xfer && last, !rsp_valid && !req_stall)

endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
module testbench;
   import tfwb_pkg::*;

   localparam int BOARD_SIZE = 5;
   localparam int CYCLE_LIMIT = 150000;
   localparam int LONG_HOLD = 150;
   localparam int SETTLE_CYCLES = BOARD_SIZE + 4;

   typedef struct packed {
      logic                       kind;
      logic                       active;
      logic [CLASS_W-1:0]         slot_class;
      logic signed [WEALTH_W-1:0] wealth;
      logic [IDENT_W-1:0]         ident;
   } slot_item_type;

   typedef struct packed {
      logic [RANK_W-1:0]          rank;
      logic [IDENT_W-1:0]         ident;
      logic signed [WEALTH_W-1:0] wealth;
      logic                       last;
   } board_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_kind = KIND_OFFER;
   logic                       req_slot_active = 1'b0;
   logic [CLASS_W-1:0]         req_slot_class = '0;
   logic signed [WEALTH_W-1:0] req_slot_wealth = '0;
   logic [IDENT_W-1:0]         req_slot_ident = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [RANK_W-1:0]          rsp_rank;
   logic [IDENT_W-1:0]         rsp_entry_ident;
   logic signed [WEALTH_W-1:0] rsp_entry_wealth;
   logic                       rsp_last_entry;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CLASS_W-1:0]         csr_class_limit = '0;

   top_five_wealth_board_top #(
      .BOARD_SIZE(BOARD_SIZE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_slot_active(req_slot_active),
      .req_slot_class(req_slot_class),
      .req_slot_wealth(req_slot_wealth),
      .req_slot_ident(req_slot_ident),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_rank(rsp_rank),
      .rsp_entry_ident(rsp_entry_ident),
      .rsp_entry_wealth(rsp_entry_wealth),
      .rsp_last_entry(rsp_last_entry),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_class_limit(csr_class_limit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shared state between the sequencing process, the driver and the checker.
   slot_item_type              req_items_pending[$];
   board_entry_type            board_entries_due[$];
   logic signed [WEALTH_W-1:0] board_wealth_model[BOARD_SIZE];
   logic [IDENT_W-1:0]         board_ident_model[BOARD_SIZE];
   logic [CLASS_W-1:0]         class_limit_model = CLASS_LIMIT_RESET;
   int                         mismatch_count = 0;
   int                         cycle_count = 0;
   int                         burst_left = 4;
   int                         gap_left = 0;
   int                         hold_left = 0;
   logic                       hold_request = 1'b0;
   logic                       csr_want = 1'b0;
   logic [CLASS_W-1:0]         csr_value = '0;
   int                         stall_mode = 0;
   int                         stall_tick = 0;

   function automatic void report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
   endfunction

   function automatic void clear_model_board();
      for (int i = 0; i < BOARD_SIZE; i++) begin
         board_wealth_model[i] = EMPTY_WEALTH;
         board_ident_model[i] = EMPTY_IDENT;
      end
   endfunction

   function automatic void enter_slot(slot_item_type it);
      int pos;
      if (it.active == 1'b0 || it.slot_class >= class_limit_model) return;
      if (!($signed(it.wealth) > board_wealth_model[BOARD_SIZE-1])) return;
      // A newcomer settles below every entry that is equal or richer.
      pos = BOARD_SIZE - 1;
      while (pos > 0 && $signed(it.wealth) > board_wealth_model[pos-1]) pos--;
      for (int i = BOARD_SIZE - 1; i > pos; i--) begin
         board_wealth_model[i] = board_wealth_model[i-1];
         board_ident_model[i] = board_ident_model[i-1];
      end
      board_wealth_model[pos] = it.wealth;
      board_ident_model[pos] = it.ident;
   endfunction

   function automatic void emit_board();
      board_entry_type e;
      for (int i = 0; i < BOARD_SIZE; i++) begin
         e.rank = i[RANK_W-1:0];
         e.ident = board_ident_model[i];
         e.wealth = board_wealth_model[i];
         e.last = (i == BOARD_SIZE - 1);
         board_entries_due.push_back(e);
      end
      clear_model_board();
   endfunction

   // Checker and predictor: results are compared before the same edge's
   // request transfer is folded into the board model.
   always @(posedge clock) begin
      board_entry_type want;
      slot_item_type   got_item;
      if (reset) begin
         clear_model_board();
         class_limit_model = CLASS_LIMIT_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (board_entries_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result rank %0d ident %h wealth %0d",
                  rsp_rank, rsp_entry_ident, rsp_entry_wealth));
            end else begin
               want = board_entries_due.pop_front();
               if (rsp_rank !== want.rank || rsp_entry_ident !== want.ident ||
                   rsp_entry_wealth !== want.wealth || rsp_last_entry !== want.last) begin
                  report_mismatch($sformatf(
                     "exp rank %0d ident %h wealth %0d last %0b, got %0d %h %0d %0b",
                     want.rank, want.ident, want.wealth, want.last,
                     rsp_rank, rsp_entry_ident, rsp_entry_wealth, rsp_last_entry));
               end
            end
         end
         if (req_valid && !req_stall) begin
            got_item.kind = req_kind;
            got_item.active = req_slot_active;
            got_item.slot_class = req_slot_class;
            got_item.wealth = req_slot_wealth;
            got_item.ident = req_slot_ident;
            if (got_item.kind == KIND_FINISH) emit_board();
            else enter_slot(got_item);
         end
         if (csr_valid && csr_ready) class_limit_model = csr_class_limit;
      end
   end

   // Request driver: bursts of items from the pending queue with random gaps.
   always @(posedge clock) begin
      slot_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_items_pending.size() != 0) begin
               next_item = req_items_pending.pop_front();
               req_valid <= 1'b1;
               req_kind <= next_item.kind;
               req_slot_active <= next_item.active;
               req_slot_class <= next_item.slot_class;
               req_slot_wealth <= next_item.wealth;
               req_slot_ident <= next_item.ident;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (csr_valid && csr_ready) begin
            csr_valid <= 1'b0;
         end else if (!csr_valid && csr_want) begin
            csr_valid <= 1'b1;
            csr_class_limit <= csr_value;
            csr_want = 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted in cycles.
   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      else if (hold_request) hold_left <= LONG_HOLD;
   end

   // Receiver stall pattern; the mode is redrawn at random from four modes on a tick counter.
   always @(posedge clock) begin
      logic pattern_stall;
      stall_tick++;
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: pattern_stall = 1'b0;
         1: pattern_stall = ($urandom_range(0, 1) != 0);
         2: pattern_stall = ($urandom_range(0, 3) == 0);
         default: pattern_stall = (stall_tick % 5) < 2;
      endcase
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= pattern_stall || (hold_left != 0);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic slot_item_type slot_of(logic kind, logic active,
                                             logic [CLASS_W-1:0] cls,
                                             logic [WEALTH_W-1:0] wealth,
                                             logic [IDENT_W-1:0] ident);
      slot_item_type it;
      it.kind = kind;
      it.active = active;
      it.slot_class = cls;
      it.wealth = wealth;
      it.ident = ident;
      return it;
   endfunction

   function automatic logic [WEALTH_W-1:0] random_wealth();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 15);
         1: return $urandom;
         2: return -$urandom_range(1, 20);
         3: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom_range(0, 1000);
      endcase
   endfunction

   function automatic logic [CLASS_W-1:0] random_class(logic [CLASS_W-1:0] limit);
      if (limit != 0 && $urandom_range(0, 3) != 0) return CLASS_W'($urandom_range(0, limit - 1));
      return CLASS_W'($urandom_range(0, 255));
   endfunction

   function automatic slot_item_type random_offer(logic [CLASS_W-1:0] limit);
      return slot_of(KIND_OFFER, $urandom_range(0, 7) != 0, random_class(limit),
                     random_wealth(), IDENT_W'($urandom_range(0, 65535)));
   endfunction

   function automatic slot_item_type random_finish();
      return slot_of(KIND_FINISH, $urandom_range(0, 1) != 0, CLASS_W'($urandom_range(0, 255)),
                     $urandom, IDENT_W'($urandom_range(0, 65535)));
   endfunction

   task automatic queue_directed();
      // Empty board, then the ignore rules, ties and a drop-out at the bottom.
      req_items_pending.push_back(slot_of(KIND_FINISH, 1'b0, 8'hFF, 32'h8000_0000, 16'h0000));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd0, 32'd0, 16'h0001));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd0, 32'hFFFF_FFFF, 16'h0002));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd0, 32'h8000_0000, 16'h0002));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b0, 8'd0, 32'h7FFF_FFFF, 16'h0003));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd10, 32'd500, 16'h0004));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd255, 32'd500, 16'h0004));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd9, 32'd100, 16'h0000));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd0, 32'd100, 16'h1111));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd3, 32'd100, 16'h2222));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd0, 32'h7FFF_FFFF, 16'hFFFF));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd0, 32'd1, 16'h0005));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd0, 32'd1, 16'h0006));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd0, 32'd200, 16'h0007));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd0, 32'd100, 16'h0008));
      req_items_pending.push_back(slot_of(KIND_OFFER, 1'b1, 8'd0, 32'd101, 16'h0009));
      req_items_pending.push_back(slot_of(KIND_FINISH, 1'b1, 8'd0, 32'h7FFF_FFFF, 16'hFFFF));
      req_items_pending.push_back(slot_of(KIND_FINISH, 1'b0, 8'd0, 32'd0, 16'h0000));
   endtask

   // Mostly runs of offers closed by a finish, with some loose noise items.
   task automatic queue_random_phase(int count, logic [CLASS_W-1:0] limit);
      int queued;
      int run;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(0, 9) < 8) begin
            run = $urandom_range(1, 10);
            repeat (run) req_items_pending.push_back(random_offer(limit));
            req_items_pending.push_back(random_finish());
            queued += run + 1;
         end else begin
            if ($urandom_range(0, 1)) req_items_pending.push_back(random_finish());
            else req_items_pending.push_back(slot_of(KIND_OFFER, $urandom_range(0, 1) != 0,
               CLASS_W'($urandom_range(0, 255)), $urandom, IDENT_W'($urandom_range(0, 65535))));
            queued++;
         end
      end
   endtask

   task automatic wait_idle();
      while (req_items_pending.size() != 0 || req_valid || board_entries_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_class_limit(logic [CLASS_W-1:0] value);
      csr_value = value;
      csr_want = 1'b1;
      @(negedge clock);
      while (csr_want || csr_valid) @(negedge clock);
   endtask

   initial begin
      logic [CLASS_W-1:0] limit_now;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      queue_directed();
      wait_idle();
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: limit_now = 8'd255;
            1: limit_now = 8'd0;
            2: limit_now = 8'd1;
            3: limit_now = CLASS_LIMIT_RESET;
            default: limit_now = CLASS_W'($urandom_range(2, 254));
         endcase
         write_class_limit(limit_now);
         if (p == 0) begin
            // The receiver holds off while the sender keeps offering items.
            hold_request = 1'b1;
            @(negedge clock);
            hold_request = 1'b0;
         end
         queue_random_phase(34, limit_now);
         wait_idle();
      end
      if (mismatch_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire
